// File: src/uqsh_pkg.sv
`timescale 1ns / 1ps

package uqsh_pkg;

    localparam int MAX_LINE_BYTES = 4095;
    localparam int TAKEN_W        = 13;

    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_GOT_LEAD = 2'd1;
    localparam logic [1:0] MODE_GOT_MID  = 2'd2;
    localparam logic [1:0] MODE_SKIP     = 2'd3;

    localparam logic [7:0] BYTE_EOL      = 8'h00;
    localparam logic [7:0] BYTE_LEAD     = 8'hE2;
    localparam logic [7:0] BYTE_MID      = 8'h80;
    localparam logic [7:0] BYTE_LSQ      = 8'h98;
    localparam logic [7:0] BYTE_RSQ      = 8'h99;
    localparam logic [7:0] BYTE_LDQ      = 8'h9C;
    localparam logic [7:0] BYTE_RDQ      = 8'h9D;
    localparam logic [7:0] BYTE_CONT_END = 8'hC0;

    localparam logic [6:0] CHAR_APOS     = 7'h27;
    localparam logic [6:0] CHAR_QUOTE    = 7'h22;
    localparam logic [6:0] CHAR_NONE     = 7'h00;

    localparam int HASH_SHIFT = 5;

    typedef struct packed {
        logic        has;
        logic [6:0]  ch;
        logic [31:0] hash;
        logic        done;
    } result_t;

endpackage

// File: src/uqsh_in_stage.sv
`timescale 1ns / 1ps

module uqsh_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output logic       in_stall,
    output logic       s1_valid,
    output logic [7:0] s1_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= data_byte;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

endmodule

// File: src/uqsh_decode.sv
`timescale 1ns / 1ps

module uqsh_decode
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [7:0]            byte_in,
    output uqsh_pkg::result_t     res
);

    logic [1:0]                     mode_reg;
    logic [1:0]                     mode_next;
    logic [31:0]                    hash_reg;
    logic [31:0]                    hash_next;
    logic [uqsh_pkg::TAKEN_W-1:0]   taken_reg;
    logic [uqsh_pkg::TAKEN_W-1:0]   taken_next;
    logic                           emit;
    logic [6:0]                     ch;
    logic                           is_cont;
    logic [31:0]                    hash_upd;

    assign is_cont  = byte_in[7] && (byte_in < uqsh_pkg::BYTE_CONT_END);
    assign hash_upd = {hash_reg[31-uqsh_pkg::HASH_SHIFT:0], {uqsh_pkg::HASH_SHIFT{1'b0}}}
                      + {25'd0, ch};

    always_comb
    begin
        mode_next  = mode_reg;
        hash_next  = hash_reg;
        taken_next = taken_reg;
        emit       = 1'b0;
        ch         = uqsh_pkg::CHAR_NONE;
        res.has    = 1'b0;
        res.ch     = uqsh_pkg::CHAR_NONE;
        res.hash   = hash_reg;
        res.done   = 1'b0;
        if (byte_in == uqsh_pkg::BYTE_EOL)
        begin
            res.has    = 1'b1;
            res.done   = 1'b1;
            mode_next  = uqsh_pkg::MODE_NORMAL;
            hash_next  = '0;
            taken_next = '0;
        end
        else if (taken_reg < uqsh_pkg::TAKEN_W'(uqsh_pkg::MAX_LINE_BYTES))
        begin
            taken_next = taken_reg + 1'b1;
            if (mode_reg == uqsh_pkg::MODE_GOT_LEAD && byte_in == uqsh_pkg::BYTE_MID)
            begin
                mode_next = uqsh_pkg::MODE_GOT_MID;
            end
            else if (mode_reg == uqsh_pkg::MODE_GOT_MID
                     && (byte_in == uqsh_pkg::BYTE_LSQ || byte_in == uqsh_pkg::BYTE_RSQ))
            begin
                mode_next = uqsh_pkg::MODE_NORMAL;
                emit      = 1'b1;
                ch        = uqsh_pkg::CHAR_APOS;
            end
            else if (mode_reg == uqsh_pkg::MODE_GOT_MID
                     && (byte_in == uqsh_pkg::BYTE_LDQ || byte_in == uqsh_pkg::BYTE_RDQ))
            begin
                mode_next = uqsh_pkg::MODE_NORMAL;
                emit      = 1'b1;
                ch        = uqsh_pkg::CHAR_QUOTE;
            end
            else if (mode_reg != uqsh_pkg::MODE_NORMAL && is_cont)
            begin
                mode_next = uqsh_pkg::MODE_SKIP;
            end
            else if (!byte_in[7])
            begin
                mode_next = uqsh_pkg::MODE_NORMAL;
                emit      = 1'b1;
                ch        = byte_in[6:0];
            end
            else if (byte_in == uqsh_pkg::BYTE_LEAD)
            begin
                mode_next = uqsh_pkg::MODE_GOT_LEAD;
            end
            else
            begin
                mode_next = uqsh_pkg::MODE_SKIP;
            end
            if (emit)
            begin
                hash_next = hash_upd;
                res.has   = 1'b1;
                res.ch    = ch;
                res.hash  = hash_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= uqsh_pkg::MODE_NORMAL;
            hash_reg  <= '0;
            taken_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            hash_reg  <= hash_next;
            taken_reg <= taken_next;
        end
    end

    // line counter never runs past the limit
    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= uqsh_pkg::TAKEN_W'(uqsh_pkg::MAX_LINE_BYTES))
        else $error("line byte count past limit");

    // end of line returns decoder to a clean state
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && byte_in == uqsh_pkg::BYTE_EOL
        |=> mode_reg == uqsh_pkg::MODE_NORMAL && hash_reg == 32'd0 && taken_reg == '0)
        else $error("state not cleared after end of line");

endmodule

// File: src/utf8_quote_sanitizer_hash.sv
`timescale 1ns / 1ps

// datapath: an accepted byte is held in the input stage register, its result in the output register
// throughput: one byte per cycle unless stalled, set by the single decode and shift-add stage
// bytes that yield no result still take one slot in the decode stage
// reset: rst_n asynchronous active low, clears decode mode, hash, count and valids

module utf8_quote_sanitizer_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_char,
    output logic [31:0] line_hash,
    output logic        line_done
);

    logic              s1_valid;
    logic [7:0]        s1_byte;
    logic              advance;
    uqsh_pkg::result_t res;

    logic              valid_reg;
    logic              valid_next;
    logic [6:0]        char_reg;
    logic [31:0]       hash_reg;
    logic              done_reg;

    assign advance = s1_valid && (!valid_reg || !out_stall);

    uqsh_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .advance   (advance),
        .in_stall  (in_stall),
        .s1_valid  (s1_valid),
        .s1_byte   (s1_byte)
    );

    uqsh_decode u_dec
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (s1_byte),
        .res     (res)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res.has;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.has)
        begin
            char_reg <= res.ch;
            hash_reg <= res.hash;
            done_reg <= res.done;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign line_hash = hash_reg;
    assign line_done = done_reg;

    // input side only blocks while the decode stage holds a byte
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid)
        else $error("input stalled with empty decode stage");

    // end of line always lands as a done result
    a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_byte == uqsh_pkg::BYTE_EOL |=> valid_reg && done_reg)
        else $error("end of line lost");

    // end result carries no character
    a_done_char: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && done_reg |-> char_reg == uqsh_pkg::CHAR_NONE)
        else $error("character on end result");

endmodule
